FILE: hdl/bffl_pkg.sv
// ----------------------------------------------------------------------------
// Free list allocator package
// Shared constants, command and response types and header entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bffl_pkg;

    localparam int HEAP_BYTES      = 1048576;
    localparam int HEADER_BYTES    = 16;
    localparam int MIN_SPLIT_BYTES = 8;
    localparam int REGION_BYTES    = 65536;
    localparam int LARGE_LIMIT     = 4096;

    localparam int OFF_W     = 20;
    localparam int SIZE_W    = 17;
    localparam int WANT_W    = 13;
    localparam int HDR_DEPTH = HEAP_BYTES / 8;
    localparam int IDX_W     = $clog2(HDR_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP = '1;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_NO_FIT    = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] request_bytes;
        logic [19:0] address;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] data_address;
        logic [15:0] granted_bytes;
    } rsp_t;

    typedef struct packed {
        logic              link;
        logic [OFF_W-1:0]  next;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    function automatic logic [SIZE_W-1:0] data_of(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] r;
        r = (sz >= SIZE_W'(HEADER_BYTES)) ? sz - SIZE_W'(HEADER_BYTES) : '0;
        return r;
    endfunction

    function automatic logic splittable(input logic [SIZE_W-1:0] sz,
                                        input logic [WANT_W-1:0] want);
        logic [SIZE_W:0] lim;
        lim = (SIZE_W+1)'(2 * HEADER_BYTES + MIN_SPLIT_BYTES) + (SIZE_W+1)'(want);
        return {1'b0, sz} >= lim;
    endfunction

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? SIZE_CAP : s[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/best_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Best fit free list allocator
// Address-sorted free list of block headers held in a header RAM, with
// best fit allocation, splitting, and coalescing on free.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | content
//  cmd     | cmd_valid, cmd_stall, cmd    | in        | mode, size, address
//  rsp     | rsp_valid, rsp_stall, rsp    | out       | status, address, bytes
//
// One transaction is processed at a time. An allocate walks the list from the
// head until a fit that cannot be split is met or the list ends; a free or a
// region add walks the nodes at or below the freed or added header. A command
// is taken only in the idle state, after the last response is posted. The
// header RAM port (one read, one write a cycle) paces these walks. A response
// stalled in the output register holds the next one back, and the command
// channel stalls meanwhile. Reset leaves the list empty.
`default_nettype none

module best_fit_free_list_allocator
    import bffl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    typedef enum logic [4:0] {
        S_IDLE, S_A_WALK, S_A_DEC, S_A_WB, S_A_RP, S_A_WP,
        S_F_WALK, S_F_RH, S_F_WH, S_F_RP, S_F_WP, S_F_RH2, S_F_CH, S_F_WN,
        S_F_M2, S_F_CP, S_F_WM, S_DONE
    } state_t;

    state_t            state_reg;
    logic              add_reg;
    logic [WANT_W-1:0] want_reg;
    logic [OFF_W-1:0]  h_reg, cur_reg, p_reg, last_reg, best_reg, bprev_reg, fn_reg;
    logic              has_reg, pv_reg, lastv_reg, found_reg, bprevv_reg, fl_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SIZE_W-1:0] bestd_reg, size_fin_reg;
    hdr_t              best_e_reg, e_reg;
    logic              head_valid_reg;
    logic [OFF_W-1:0]  head_reg;
    rsp_t              res_reg, rsp_reg;
    logic              rsp_valid_reg;

    logic              ram_we;
    logic [OFF_W-1:0]  ram_woff, ram_roff;
    hdr_t              ram_wdata, ram_rdata;
    logic [37:0]       ram_rbits;

    logic [CNT_W-1:0]  cnt_inc;
    logic              cnt_ok;
    logic [SIZE_W-1:0] d_cur;
    logic              fit, brk, a_cont, f_cont, split;
    logic [OFF_W-1:0]  nh;
    logic [WANT_W-1:0] want_in;
    logic [OFF_W-1:0]  h_free;

    assign ram_rdata = hdr_t'(ram_rbits);

    bffl_ram #(
        .WIDTH($bits(hdr_t)),
        .DEPTH(HDR_DEPTH)
    ) u_hdr_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_woff[OFF_W-1:3]),
        .wdata(ram_wdata),
        .raddr(ram_roff[OFF_W-1:3]),
        .rdata(ram_rbits)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign cnt_ok  = cnt_inc < CNT_W'(HDR_DEPTH);
    assign d_cur   = data_of(ram_rdata.size);
    assign fit     = ({4'b0, want_reg} <= d_cur) && (!found_reg || bestd_reg > d_cur);
    assign brk     = fit && !splittable(ram_rdata.size, want_reg);
    assign a_cont  = !brk && ram_rdata.link && cnt_ok;
    assign f_cont  = ram_rdata.link && (ram_rdata.next <= h_reg) && cnt_ok;
    assign split   = splittable(best_e_reg.size, want_reg);
    assign nh      = best_reg + OFF_W'(HEADER_BYTES) + OFF_W'(want_reg);
    assign want_in = (WANT_W'(cmd.request_bytes) + WANT_W'(7)) & ~WANT_W'(7);
    assign h_free  = (cmd.address - OFF_W'(HEADER_BYTES)) & ~OFF_W'(7);

    // RAM port control; the read address may follow the data just read.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_woff  = h_reg;
        ram_wdata = '0;
        ram_roff  = h_reg;
        case (state_reg)
            S_IDLE:   ram_roff = head_reg;
            S_A_WALK: ram_roff = ram_rdata.next;
            S_A_DEC:
            begin
                ram_we    = found_reg && split;
                ram_woff  = nh;
                ram_wdata = '{link: best_e_reg.link, next: best_e_reg.next,
                              size: data_of(best_e_reg.size) - SIZE_W'(want_reg)};
            end
            S_A_WB:
            begin
                ram_we    = 1'b1;
                ram_woff  = best_reg;
                ram_wdata = '{link: 1'b0, next: '0, size: size_fin_reg};
            end
            S_A_RP:   ram_roff = bprev_reg;
            S_A_WP:
            begin
                ram_we    = 1'b1;
                ram_woff  = bprev_reg;
                ram_wdata = '{link: fl_reg, next: fn_reg, size: ram_rdata.size};
            end
            S_F_WALK: ram_roff = ram_rdata.next;
            S_F_WH:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{link: has_reg, next: has_reg ? cur_reg : '0,
                              size: add_reg ? SIZE_W'(REGION_BYTES) : ram_rdata.size};
            end
            S_F_RP:   ram_roff = p_reg;
            S_F_WP:
            begin
                ram_we    = 1'b1;
                ram_woff  = p_reg;
                ram_wdata = '{link: 1'b1, next: h_reg, size: ram_rdata.size};
            end
            S_F_CH:   ram_roff = ram_rdata.next;
            S_F_WN:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{link: ram_rdata.link, next: ram_rdata.next,
                              size: sat_add(e_reg.size, ram_rdata.size)};
            end
            S_F_M2:   ram_roff = p_reg;
            S_F_WM:
            begin
                ram_we    = 1'b1;
                ram_woff  = p_reg;
                ram_wdata = '{link: ram_rdata.link, next: ram_rdata.next,
                              size: sat_add(e_reg.size, ram_rdata.size)};
            end
            default:  ram_roff = h_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= 1'b0;
            head_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        lastv_reg <= 1'b0;
                        pv_reg    <= 1'b0;
                        want_reg  <= want_in;
                        cur_reg   <= head_reg;
                        has_reg   <= head_valid_reg;
                        add_reg   <= (cmd.mode == MODE_ADD);
                        unique case (cmd.mode) inside
                            MODE_ALLOC:
                            begin
                                if (cmd.request_bytes == '0)
                                begin
                                    res_reg   <= '{status: ST_ZERO, data_address: '0,
                                                   granted_bytes: '0};
                                    state_reg <= S_DONE;
                                end
                                else if (want_in >= WANT_W'(LARGE_LIMIT))
                                begin
                                    res_reg   <= '{status: ST_TOO_LARGE, data_address: '0,
                                                   granted_bytes: '0};
                                    state_reg <= S_DONE;
                                end
                                else if (!head_valid_reg)
                                begin
                                    res_reg   <= '{status: ST_NO_FIT, data_address: '0,
                                                   granted_bytes: '0};
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    res_reg   <= '0;
                                    state_reg <= S_A_WALK;
                                end
                            end
                            MODE_FREE, MODE_ADD:
                            begin
                                res_reg <= '0;
                                if (cmd.mode == MODE_FREE)
                                begin
                                    h_reg <= h_free;
                                end
                                else
                                begin
                                    h_reg <= cmd.address & ~OFF_W'(7);
                                end
                                if (head_valid_reg && head_reg <= ((cmd.mode == MODE_FREE)
                                        ? h_free : (cmd.address & ~OFF_W'(7))))
                                begin
                                    state_reg <= S_F_WALK;
                                end
                                else
                                begin
                                    state_reg <= S_F_RH;
                                end
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_A_WALK:
                begin
                    if (fit)
                    begin
                        found_reg  <= 1'b1;
                        best_reg   <= cur_reg;
                        bestd_reg  <= d_cur;
                        best_e_reg <= ram_rdata;
                        bprev_reg  <= last_reg;
                        bprevv_reg <= lastv_reg;
                    end
                    lastv_reg <= 1'b1;
                    last_reg  <= cur_reg;
                    cnt_reg   <= cnt_inc;
                    cur_reg   <= ram_rdata.next;
                    if (!a_cont)
                    begin
                        state_reg <= S_A_DEC;
                    end
                end
                S_A_DEC:
                begin
                    if (!found_reg)
                    begin
                        res_reg.status <= ST_NO_FIT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (split)
                        begin
                            fl_reg       <= 1'b1;
                            fn_reg       <= nh;
                            size_fin_reg <= SIZE_W'(HEADER_BYTES) + SIZE_W'(want_reg);
                        end
                        else
                        begin
                            fl_reg       <= best_e_reg.link;
                            fn_reg       <= best_e_reg.next;
                            size_fin_reg <= best_e_reg.size;
                        end
                        state_reg <= S_A_WB;
                    end
                end
                S_A_WB:
                begin
                    res_reg <= '{status: ST_OK,
                                 data_address: best_reg + OFF_W'(HEADER_BYTES),
                                 granted_bytes: 16'(data_of(size_fin_reg))};
                    if (bprevv_reg)
                    begin
                        state_reg <= S_A_RP;
                    end
                    else
                    begin
                        head_valid_reg <= fl_reg;
                        head_reg       <= fl_reg ? fn_reg : '0;
                        state_reg      <= S_DONE;
                    end
                end
                S_A_RP:   state_reg <= S_A_WP;
                S_A_WP:   state_reg <= S_DONE;
                S_F_WALK:
                begin
                    pv_reg  <= 1'b1;
                    p_reg   <= cur_reg;
                    has_reg <= ram_rdata.link;
                    cur_reg <= ram_rdata.next;
                    cnt_reg <= cnt_inc;
                    if (!f_cont)
                    begin
                        state_reg <= S_F_RH;
                    end
                end
                S_F_RH:   state_reg <= S_F_WH;
                S_F_WH:
                begin
                    if (pv_reg)
                    begin
                        state_reg <= S_F_RP;
                    end
                    else
                    begin
                        head_valid_reg <= 1'b1;
                        head_reg       <= h_reg;
                        state_reg      <= add_reg ? S_DONE : S_F_RH2;
                    end
                end
                S_F_RP:   state_reg <= S_F_WP;
                S_F_WP:   state_reg <= add_reg ? S_DONE : S_F_RH2;
                S_F_RH2:  state_reg <= S_F_CH;
                S_F_CH:
                begin
                    e_reg <= ram_rdata;
                    if (ram_rdata.link && ({1'b0, h_reg} + (OFF_W+1)'(ram_rdata.size)
                            == {1'b0, ram_rdata.next}))
                    begin
                        state_reg <= S_F_WN;
                    end
                    else
                    begin
                        state_reg <= S_F_M2;
                    end
                end
                S_F_WN:   state_reg <= S_F_M2;
                S_F_M2:   state_reg <= pv_reg ? S_F_CP : S_DONE;
                S_F_CP:
                begin
                    e_reg <= ram_rdata;
                    if ({1'b0, p_reg} + (OFF_W+1)'(ram_rdata.size) == {1'b0, h_reg})
                    begin
                        state_reg <= S_F_WM;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_F_WM:   state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bffl_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bffl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: bench/best_fit_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// Best fit free list allocator testbench
// Drives allocate, free, add-region and no-op commands through the command
// channel, predicts each response with an in-bench model of the free list,
// and compares every response field by field while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_free_list_allocator_test;
    import bffl_pkg::*;

    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    best_fit_free_list_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Shadow copy of the heap headers and the list head.
    bit                hdr_link [HDR_DEPTH];
    logic [OFF_W-1:0]  hdr_next [HDR_DEPTH];
    logic [SIZE_W-1:0] hdr_size [HDR_DEPTH];
    bit                head_valid;
    int unsigned       head_off;

    cmd_t        cmd_backlog[$];
    rsp_t        result_forecast[$];
    int unsigned live_blocks[$];
    int unsigned region_bases[$];
    int          failures;
    bit          cmd_taken;
    bit          hold_req;
    bit          hold_done;
    int          hold_cnt;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    int          stall_mode;

    always #4 clk = ~clk;

    function automatic int unsigned usable(input int unsigned sz);
        return (sz >= HEADER_BYTES) ? sz - HEADER_BYTES : 0;
    endfunction

    function automatic bit can_split(input int unsigned sz, input int unsigned want);
        return longint'(sz) >= longint'(2 * HEADER_BYTES + MIN_SPLIT_BYTES + want);
    endfunction

    function automatic int unsigned slot(input int unsigned off);
        return (off >> 3) % HDR_DEPTH;
    endfunction

    function automatic int unsigned capped(input longint unsigned v);
        return (v > SIZE_CAP) ? int'(SIZE_CAP) : int'(v);
    endfunction

    function automatic bit link_in(input int unsigned h, output int unsigned prev);
        bit          has;
        bit          pv;
        int unsigned cur;
        int unsigned n;
        has  = head_valid;
        pv   = 0;
        cur  = head_off;
        prev = 0;
        for (n = 0; n < HDR_DEPTH && has; n++)
        begin
            if (cur > h)
                break;
            pv   = 1;
            prev = cur;
            has  = hdr_link[slot(cur)];
            cur  = hdr_next[slot(cur)];
        end
        hdr_link[slot(h)] = has;
        hdr_next[slot(h)] = has ? OFF_W'(cur) : '0;
        if (pv)
        begin
            hdr_link[slot(prev)] = 1;
            hdr_next[slot(prev)] = OFF_W'(h);
        end
        else
        begin
            head_valid = 1;
            head_off   = h;
        end
        return pv;
    endfunction

    function automatic rsp_t heap_response(input cmd_t c);
        rsp_t        r;
        int unsigned want;
        int unsigned cur;
        int unsigned last;
        int unsigned best;
        int unsigned bprev;
        int unsigned n;
        int unsigned hi;
        int unsigned ci;
        int unsigned d;
        int unsigned nh;
        int unsigned h;
        int unsigned p;
        int unsigned ni;
        int unsigned fn;
        bit          has;
        bit          lastv;
        bit          found;
        bit          bprevv;
        bit          fl;
        bit          pv;
        r = '0;
        case (c.mode)
            MODE_ALLOC:
            begin
                if (c.request_bytes == 0)
                begin
                    r.status = ST_ZERO;
                    return r;
                end
                want = (c.request_bytes + 7) & ~32'd7;
                if (want >= LARGE_LIMIT)
                begin
                    r.status = ST_TOO_LARGE;
                    return r;
                end
                cur = head_off; has = head_valid;
                last = 0; lastv = 0; found = 0; best = 0; bprev = 0; bprevv = 0;
                for (n = 0; n < HDR_DEPTH && has; n++)
                begin
                    ci = slot(cur);
                    d  = usable(hdr_size[ci]);
                    if (d >= want && (!found || usable(hdr_size[slot(best)]) > d))
                    begin
                        found = 1; best = cur; bprev = last; bprevv = lastv;
                        if (!can_split(hdr_size[ci], want))
                            break;
                    end
                    lastv = 1;
                    last  = cur;
                    has   = hdr_link[ci];
                    cur   = hdr_next[ci];
                end
                if (!found)
                begin
                    r.status = ST_NO_FIT;
                    return r;
                end
                hi = slot(best);
                if (can_split(hdr_size[hi], want))
                begin
                    nh = ((best + HEADER_BYTES + want) % HEAP_BYTES) & ~32'd7;
                    hdr_link[slot(nh)] = hdr_link[hi];
                    hdr_next[slot(nh)] = hdr_next[hi];
                    hdr_size[slot(nh)] = SIZE_W'(usable(hdr_size[hi]) - want);
                    hdr_size[hi] = SIZE_W'(HEADER_BYTES + want);
                    hdr_link[hi] = 1;
                    hdr_next[hi] = OFF_W'(nh);
                end
                fl = hdr_link[hi];
                fn = hdr_next[hi];
                hdr_link[hi] = 0;
                hdr_next[hi] = '0;
                if (bprevv)
                begin
                    hdr_link[slot(bprev)] = fl;
                    hdr_next[slot(bprev)] = OFF_W'(fn);
                end
                else
                begin
                    head_valid = fl;
                    head_off   = fl ? fn : 0;
                end
                r.status        = ST_OK;
                r.data_address  = 20'((best + HEADER_BYTES) % HEAP_BYTES);
                r.granted_bytes = 16'(usable(hdr_size[hi]));
            end
            MODE_FREE:
            begin
                h  = ((c.address % HEAP_BYTES) + HEAP_BYTES - HEADER_BYTES) % HEAP_BYTES
                     & ~32'd7;
                hi = slot(h);
                pv = link_in(h, p);
                if (hdr_link[hi] && longint'(h) + hdr_size[hi] == hdr_next[hi])
                begin
                    ni = slot(hdr_next[hi]);
                    hdr_size[hi] = SIZE_W'(capped(longint'(hdr_size[hi]) + hdr_size[ni]));
                    hdr_link[hi] = hdr_link[ni];
                    hdr_next[hi] = hdr_next[ni];
                end
                if (pv && longint'(p) + hdr_size[slot(p)] == h)
                begin
                    hdr_size[slot(p)] = SIZE_W'(capped(longint'(hdr_size[slot(p)])
                                                       + hdr_size[hi]));
                    hdr_link[slot(p)] = hdr_link[hi];
                    hdr_next[slot(p)] = hdr_next[hi];
                end
            end
            MODE_ADD:
            begin
                h = (c.address % HEAP_BYTES) & ~32'd7;
                hdr_size[slot(h)] = SIZE_W'(REGION_BYTES);
                void'(link_in(h, p));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Queues a command, predicts its response and keeps track of live blocks.
    task automatic issue(input logic [1:0] mode, input int unsigned req,
                         input int unsigned addr);
        cmd_t c;
        rsp_t r;
        c.mode          = mode;
        c.request_bytes = 12'(req);
        c.address       = 20'(addr);
        r = heap_response(c);
        cmd_backlog.push_back(c);
        result_forecast.push_back(r);
        if (mode == MODE_ALLOC && r.status == ST_OK)
            live_blocks.push_back(r.data_address);
    endtask

    task automatic add_region();
        int k;
        if (region_bases.size() == 0)
            return;
        k = $urandom_range(0, region_bases.size() - 1);
        issue(MODE_ADD, $urandom, region_bases[k] + $urandom_range(0, 7));
        region_bases.delete(k);
    endtask

    task automatic free_one();
        int k;
        k = $urandom_range(0, live_blocks.size() - 1);
        // Low bits below the header alignment must not change the block freed.
        issue(MODE_FREE, $urandom, live_blocks[k] + $urandom_range(0, 7));
        live_blocks.delete(k);
    endtask

    task automatic random_item();
        int unsigned pick;
        int unsigned req;
        rsp_t        last_r;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            issue(MODE_NOP, $urandom, $urandom);
        else if (pick < 6)
            issue(MODE_ALLOC, ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(4089, 4095),
                  $urandom);
        else if (pick < 50 && live_blocks.size() > 0)
            free_one();
        else
        begin
            req = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 256)
                                              : $urandom_range(1, 4088);
            issue(MODE_ALLOC, req, $urandom);
            last_r = result_forecast[$];
            if (last_r.status == ST_NO_FIT)
            begin
                // Software reaction: add a region and try again.
                add_region();
                issue(MODE_ALLOC, req, $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        wait (cmd_backlog.size() == 0 && result_forecast.size() == 0);
    endtask

    initial
    begin
        int b;
        int i;
        clk = 0; rst_n = 0; cmd_valid = 0; cmd = '0; rsp_stall = 0;
        failures = 0; cmd_taken = 0; hold_req = 0; hold_done = 0; hold_cnt = 0;
        burst_left = 4; gap_left = 0; stall_phase = 0; stall_mode = 0;
        head_valid = 0; head_off = 0;
        for (i = 0; i < HEAP_BYTES / REGION_BYTES; i++)
            region_bases.push_back(i * REGION_BYTES);

        // Directed opening: empty heap, size extremes, every mode.
        issue(MODE_ALLOC, 8, 0);
        issue(MODE_ALLOC, 0, 20'hFFFFF);
        issue(MODE_ALLOC, 4095, 0);
        issue(MODE_ALLOC, 4089, 0);
        issue(MODE_NOP, 12'hFFF, 20'hFFFFF);
        issue(MODE_ADD, 12'hFFF, 20'hF0007);
        issue(MODE_ADD, 0, 20'h00000);
        issue(MODE_ALLOC, 4088, 0);
        issue(MODE_ALLOC, 1, 0);
        issue(MODE_ALLOC, 4088, 0);
        issue(MODE_ALLOC, 24, 0);
        issue(MODE_ALLOC, 4080, 0);
        region_bases.delete(region_bases.size() - 1);
        region_bases.delete(0);
        for (i = 0; i < 6 && live_blocks.size() > 0; i++)
            free_one();
        issue(MODE_ALLOC, 4088, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        for (b = 0; b < 4; b++)
        begin
            if (b == 1)
                hold_req = 1;
            for (i = 0; i < 200; i++)
                random_item();
            // Let the heap quiesce before the next batch.
            wait_drained();
        end
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("best_fit_free_list_allocator: match");
        else
            $display("best_fit_free_list_allocator: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("best_fit_free_list_allocator: mismatch");
        $finish;
    end

    always @(posedge clk)
        cmd_taken <= cmd_valid && !cmd_stall;

    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                cmd_valid <= 0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                cmd       <= cmd_backlog.pop_front();
                cmd_valid <= 1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                cmd_valid <= 0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_cnt = hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES)
                hold_done = 1;
            rsp_stall <= 1;
        end
        else
        begin
            stall_phase = stall_phase + 1;
            if (stall_phase % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: rsp_stall <= 0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= stall_phase[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        rsp_t want_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (result_forecast.size() == 0)
            begin
                $error("response with no command outstanding: %p", rsp);
                failures++;
            end
            else
            begin
                want_r = result_forecast.pop_front();
                if (rsp.status !== want_r.status)
                begin
                    $error("status: expected %0d, got %0d", want_r.status, rsp.status);
                    failures++;
                end
                if (rsp.data_address !== want_r.data_address)
                begin
                    $error("data_address: expected %h, got %h",
                           want_r.data_address, rsp.data_address);
                    failures++;
                end
                if (rsp.granted_bytes !== want_r.granted_bytes)
                begin
                    $error("granted_bytes: expected %0d, got %0d",
                           want_r.granted_bytes, rsp.granted_bytes);
                    failures++;
                end
            end
        end
    end

endmodule
